/* sv/rle2_pkg.sv */
package rle2_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned RUN_W    = 6;
  localparam int unsigned COLOR_W  = 2;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HDR_W    = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = WIDTH_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE = 1'b1;

  // Register reset values
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST   = 11'd800;
  localparam logic [MODE_W-1:0]  FORMAT_MODE_RST = 2'd2;

  // Stream format
  localparam logic [HDR_W-1:0]  HEADER_BYTES = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RLE     = 2'd2;

  // Row width cap: smaller of the maximum width and the column range
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned COL_LIMIT  = 1024;
  localparam int unsigned WIDTH_CAP  = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
  localparam logic [WIDTH_W-1:0] WIDTH_CAP_V = WIDTH_CAP[WIDTH_W-1:0];

  // Gray levels per colour code
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_LIGHT = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_DARK  = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 8'h00;
  localparam logic [LEVEL_W-1:0] LEVEL_LIGHT = 8'hC0;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK  = 8'h80;

  function automatic logic [LEVEL_W-1:0] gray_level(input logic [COLOR_W-1:0] color);
    logic [LEVEL_W-1:0] lvl;
    case (color)
      COLOR_WHITE: lvl = LEVEL_WHITE;
      COLOR_BLACK: lvl = LEVEL_BLACK;
      COLOR_LIGHT: lvl = LEVEL_LIGHT;
      COLOR_DARK:  lvl = LEVEL_DARK;
      default:     lvl = LEVEL_WHITE;
    endcase
    return lvl;
  endfunction

endpackage

/* sv/rle2_if.sv */
// Input channel: one stream byte per item
interface rle2_byte_if;
  import rle2_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Output channel: one pixel per item
interface rle2_pix_if;
  import rle2_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pixel_level;
  logic [COL_W-1:0]   pixel_column;
  logic [ROW_W-1:0]   pixel_row;
  logic               row_end;
  logic               run_last;

  modport source (output valid, output pixel_level, output pixel_column,
                  output pixel_row, output row_end, output run_last, input ready);
  modport sink   (input valid, input pixel_level, input pixel_column,
                  input pixel_row, input row_end, input run_last, output ready);
endinterface

/* sv/rle_two_bit_pixel_row_decoder.sv */
// Run-length decoder for a two-bit gray image stream.
// in_if carries stream bytes; out_if carries one pixel per item with its
// gray level, column, row, an end-of-row flag and a last-of-run flag.
// The first two bytes after reset are header and are dropped. Later bytes,
// in format mode 2, hold a colour in bits 7:6 and a run count in 5:0.
// A byte is taken while in_if.ready is high; a run of N pixels (N up to 63)
// then occupies the block, one pixel per cycle while out_if.ready allows,
// from a single column incrementer and width compare. in_if.ready is low
// while a run is being expanded, so the next byte waits for its last pixel;
// any other byte leaves in_if.ready high. A run's byte is loaded into the
// run and colour registers; each pixel then passes the output register.
// Header bytes, zero-count bytes and bytes in other modes produce nothing.
// The output register lets the next byte be taken while the last pixel of
// a run still waits. When out_if.ready is low the pixel holds and the run
// pauses. Reset clears the header, column and row counts and loads row
// width 800 and format mode 2; configuration is written via cfg_we_i.
module rle_two_bit_pixel_row_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rle2_byte_if.sink                       in_if,
  rle2_pix_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [rle2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rle2_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import rle2_pkg::*;

  logic [WIDTH_W-1:0] row_width_q;
  logic [MODE_W-1:0]  format_mode_q;
  logic [HDR_W-1:0]   hdr_cnt_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic               busy_q;
  logic [RUN_W-1:0]   run_q;
  logic [COLOR_W-1:0] color_q;

  logic               ovalid_q;
  logic [LEVEL_W-1:0] olevel_q;
  logic [COL_W-1:0]   ocol_q;
  logic [ROW_W-1:0]   orow_q;
  logic               oend_q;
  logic               olast_q;

  logic               in_acc;
  logic               step;
  logic [WIDTH_W-1:0] eff_width;
  logic [WIDTH_W-1:0] col_next;
  logic               at_end;
  logic [RUN_W-1:0]   in_run;

  assign in_if.ready = !busy_q;
  assign in_acc      = in_if.valid && !busy_q;
  assign in_run      = in_if.data_byte[RUN_W-1:0];
  // while a run is active, a pixel is produced when the output register is free or being drained
  assign step        = busy_q && (!ovalid_q || out_if.ready);

  // Effective width: zero as one, large values capped
  always_comb begin
    eff_width = row_width_q;
    if (row_width_q == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (row_width_q > WIDTH_CAP_V) begin
      eff_width = WIDTH_CAP_V;
    end
  end

  // Shared column increment and row-end compare
  assign col_next = {1'b0, col_q} + WIDTH_W'(1);
  assign at_end   = col_next >= eff_width;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= ROW_WIDTH_RST;
      format_mode_q <= FORMAT_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_WIDTH:   row_width_q   <= cfg_wdata_i;
        CFG_FORMAT_MODE: format_mode_q <= cfg_wdata_i[MODE_W-1:0];
        default:         row_width_q   <= row_width_q;
      endcase
    end
  end

  // Sequencer: header skip, run load, per-pixel step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      busy_q    <= 1'b0;
      run_q     <= '0;
      color_q   <= '0;
    end else begin
      if (in_acc) begin
        if (hdr_cnt_q < HEADER_BYTES) begin
          hdr_cnt_q <= hdr_cnt_q + HDR_W'(1);
        end else if (format_mode_q == MODE_RLE && in_run != '0) begin
          busy_q  <= 1'b1;
          run_q   <= in_run;
          color_q <= in_if.data_byte[BYTE_W-1 -: COLOR_W];
        end
      end
      if (step) begin
        run_q <= run_q - RUN_W'(1);
        if (run_q == RUN_W'(1)) begin
          busy_q <= 1'b0;
        end
        if (at_end) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_next[COL_W-1:0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (step) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      olevel_q <= gray_level(color_q);
      ocol_q   <= col_q;
      orow_q   <= row_q;
      oend_q   <= at_end;
      olast_q  <= (run_q == RUN_W'(1));
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.pixel_level  = olevel_q;
  assign out_if.pixel_column = ocol_q;
  assign out_if.pixel_row    = orow_q;
  assign out_if.row_end      = oend_q;
  assign out_if.run_last     = olast_q;

endmodule

/* sv/rle2_checker.sv */
module rle2_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rle2_pkg::LEVEL_W-1:0]    pixel_level,
  input logic [rle2_pkg::COL_W-1:0]      pixel_column,
  input logic [rle2_pkg::ROW_W-1:0]      pixel_row,
  input logic                            row_end,
  input logic                            run_last
);
  import rle2_pkg::*;

  // stalled pixel must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      out_valid && $stable(pixel_level) && $stable(pixel_column) && $stable(pixel_row)
      && $stable(row_end) && $stable(run_last))
    else $error("stalled pixel changed");

  // a pending non-final pixel means the run is still being expanded
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !run_last |-> !in_ready)
    else $error("byte accepted mid-run");

  // the last column always closes the row
  a_lastcol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && pixel_column == COL_W'(COL_LIMIT - 1) |-> row_end)
    else $error("last column without row end");

  // only the four gray levels appear
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (pixel_level == LEVEL_WHITE || pixel_level == LEVEL_BLACK ||
                   pixel_level == LEVEL_LIGHT || pixel_level == LEVEL_DARK))
    else $error("unexpected gray level");

endmodule

bind rle_two_bit_pixel_row_decoder rle2_checker u_rle2_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .pixel_level  (out_if.pixel_level),
  .pixel_column (out_if.pixel_column),
  .pixel_row    (out_if.pixel_row),
  .row_end      (out_if.row_end),
  .run_last     (out_if.run_last)
);
